>>> rtl/gwm_pkg.sv
// gwm_pkg: shared types, constants and helpers of the glob wildcard matcher
// depends on nothing; imported by the loader, the cell and the top level
package gwm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int NCELL       = PATTERN_MAX + 1;
  localparam int POS_W       = $clog2(PATTERN_MAX + 1);

  localparam logic [7:0] CH_ANY   = 8'h3F;  // '?'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CH_NOT   = 8'h21;  // '!'
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
  localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CASE_GAP = 8'd32;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_NAME   = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  // what a stored pattern byte is within its element
  typedef enum logic [2:0] {
    ROLE_NONE,
    ROLE_LIT,
    ROLE_ANY,
    ROLE_STAR,
    ROLE_OPEN,
    ROLE_NOT,
    ROLE_MEM,
    ROLE_CLOSE
  } role_t;

  // pattern byte write, from the loader to the cells
  typedef struct packed {
    logic             wr;
    logic [POS_W-1:0] pos;
    role_t            role;
    logic [7:0]       chr;
    logic             inv;
  } load_t;

  // per-cell control from the top level
  typedef struct packed {
    logic home;
    logic valid;
    logic wr;
  } cell_ctl_t;

  // item command broadcast to all cells
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       step;
    logic       finish;
    logic       ci;
    logic [7:0] fc;
    role_t      role;
    logic [7:0] chr;
    logic       inv;
  } cell_cmd_t;

  // signals handed from one cell to its right neighbor
  typedef struct packed {
    logic adv;
    logic clos;
    logic seg_act;
    logic seg_hit;
    logic lead;
  } link_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ci);
    logic [7:0] r;
    r = c;
    if (ci && (c inside {[CH_UP_A:CH_UP_Z]})) r = c + CASE_GAP;
    return r;
  endfunction

endpackage

>>> rtl/gwm_in_if.sv
// gwm_in_if: input channel of the glob wildcard matcher (mode, char_value)
// depends on nothing
interface gwm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_value;

  modport source (output valid, output mode, output char_value, input ready);
  modport sink   (input valid, input mode, input char_value, output ready);
endinterface

>>> rtl/gwm_out_if.sv
// gwm_out_if: result channel of the glob wildcard matcher (matched, overflow)
// depends on nothing
interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflow;

  modport source (output valid, output matched, output overflow, input ready);
  modport sink   (input valid, input matched, input overflow, output ready);
endinterface

>>> rtl/gwm_loader.sv
// gwm_loader: pattern fill count, overflow flag and incremental element decoder
// depends on gwm_pkg
module gwm_loader import gwm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             do_clear,
  input  logic             do_append,
  input  logic [7:0]       append_chr,
  output load_t            load,
  output logic [POS_W-1:0] count,
  output logic             overflowed
);

  logic [POS_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             open_r, open_nxt;   // inside an unclosed bracket
  logic             first_r, first_nxt; // next byte is the first after '['
  logic             inv_r, inv_nxt;     // bracket started with '!'
  logic             room;

  assign room = (count_r < POS_W'(PATTERN_MAX));

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    open_nxt  = open_r;
    first_nxt = first_r;
    inv_nxt   = inv_r;
    load.wr   = 1'b0;
    load.pos  = count_r;
    load.chr  = append_chr;
    load.role = ROLE_LIT;
    load.inv  = inv_r;
    if (do_clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      open_nxt  = 1'b0;
      first_nxt = 1'b0;
      inv_nxt   = 1'b0;
    end else if (do_append && !room) begin
      ovf_nxt = 1'b1;
    end else if (do_append) begin
      load.wr   = 1'b1;
      count_nxt = count_r + POS_W'(1);
      if (!open_r) begin
        case (append_chr)
          CH_ANY:  load.role = ROLE_ANY;
          CH_STAR: load.role = ROLE_STAR;
          CH_OPEN: begin
            load.role = ROLE_OPEN;
            open_nxt  = 1'b1;
            first_nxt = 1'b1;
            inv_nxt   = 1'b0;
          end
          default: load.role = ROLE_LIT;
        endcase
      end else if (first_r && append_chr == CH_NOT) begin
        load.role = ROLE_NOT;
        first_nxt = 1'b0;
        inv_nxt   = 1'b1;
      end else if (append_chr == CH_CLOSE) begin
        load.role = ROLE_CLOSE;
        open_nxt  = 1'b0;
        first_nxt = 1'b0;
      end else begin
        load.role = ROLE_MEM;
        first_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      open_r  <= 1'b0;
      first_r <= 1'b0;
      inv_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      open_r  <= open_nxt;
      first_r <= first_nxt;
      inv_r   <= inv_nxt;
    end
  end

  assign count      = count_r;
  assign overflowed = ovf_r;

endmodule

>>> rtl/gwm_cell.sv
// gwm_cell: one pattern position: stored byte, its role, active and lead bits
// depends on gwm_pkg
module gwm_cell import gwm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  cell_cmd_t cmd,
  input  link_t     link_in,
  output link_t     link_out,
  output logic      act
);

  logic [7:0] chr_r;
  role_t      role_r;
  logic       inv_r;
  logic       act_r, act_nxt;
  logic       lead_r, lead_nxt;

  role_t      role;
  logic       eq;
  logic       is_star;
  logic       nw;

  assign role    = ctl.valid ? role_r : ROLE_NONE;
  assign eq      = (fold(chr_r, cmd.ci) == cmd.fc);
  assign is_star = (role == ROLE_STAR);
  // new active bit before and after star closure from the left
  assign nw      = link_in.adv | link_in.clos | (is_star & act_r);

  always_comb begin
    link_out.adv     = 1'b0;
    link_out.seg_act = 1'b0;
    link_out.seg_hit = 1'b0;
    case (role)
      ROLE_LIT:   link_out.adv = act_r & eq;
      ROLE_ANY:   link_out.adv = act_r;
      ROLE_OPEN:  link_out.seg_act = act_r;
      ROLE_NOT: begin
        link_out.seg_act = link_in.seg_act;
        link_out.seg_hit = link_in.seg_hit;
      end
      ROLE_MEM: begin
        link_out.seg_act = link_in.seg_act;
        link_out.seg_hit = link_in.seg_hit | eq;
      end
      ROLE_CLOSE: link_out.adv = link_in.seg_act & (link_in.seg_hit ^ inv_r);
      default:    link_out.adv = 1'b0;
    endcase
    link_out.clos = nw & is_star;
    link_out.lead = lead_r & ctl.wr & (cmd.role == ROLE_STAR);
  end

  always_comb begin
    lead_nxt = lead_r;
    act_nxt  = act_r;
    if (cmd.clear) begin
      lead_nxt = ctl.home;
      act_nxt  = ctl.home;
    end else if (cmd.append) begin
      lead_nxt = lead_r | link_in.lead;
      act_nxt  = lead_nxt;
    end else if (cmd.finish) begin
      act_nxt = lead_r;
    end else if (cmd.step) begin
      act_nxt = nw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= ctl.home;
      lead_r <= ctl.home;
    end else begin
      act_r  <= act_nxt;
      lead_r <= lead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      chr_r  <= cmd.chr;
      role_r <= cmd.role;
      inv_r  <= cmd.inv;
    end
  end

  assign act = act_r;

endmodule

>>> rtl/glob_wildcard_matcher.sv
// glob_wildcard_matcher: streaming glob matcher built as a row of pattern cells
// depends on gwm_pkg, gwm_in_if, gwm_out_if, gwm_loader and gwm_cell
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------
//   in_ch    | in  | valid/ready        | mode[1:0], char_value[7:0]
//   out_ch   | out | valid/ready        | matched, overflow (end of name only)
//   cfg      | in  | cfg_we, no wait    | cfg_wdata = case_insensitive
//
// each accepted item is handled whole: a name byte advances all cells of the
// row at once, a pattern byte is decoded into its cell as it arrives
// the result of an end of name sits in an output register; the next item is
// taken in the same cycle that register is emptied or while it is empty
// a stall on out_ch holds in_ch until the pending result transfer completes
// reset (synchronous, rst_n low) empties the pattern, clears overflow and
// case folding, and leaves only position zero active
module glob_wildcard_matcher import gwm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  gwm_in_if.sink    in_ch,
  gwm_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  // configuration register
  logic ci_r;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_matched_r, out_matched_nxt;
  logic out_overflow_r, out_overflow_nxt;

  logic acc;
  logic do_clear, do_append, do_step, do_finish;

  load_t            load;
  logic [POS_W-1:0] count;
  logic             overflowed;

  cell_cmd_t        cmd;
  cell_ctl_t        ctl  [NCELL];
  link_t            link [NCELL+1];
  logic [NCELL-1:0] act_vec;

  // an item transfer happens when the result slot is free or being emptied
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    do_clear  = 1'b0;
    do_append = 1'b0;
    do_step   = 1'b0;
    do_finish = 1'b0;
    if (acc) begin
      case (mode_t'(in_ch.mode))
        MODE_CLEAR:  do_clear  = 1'b1;
        MODE_APPEND: do_append = 1'b1;
        MODE_NAME:   do_step   = 1'b1;
        MODE_END:    do_finish = 1'b1;
        default:     do_finish = 1'b0;
      endcase
    end
  end

  // pattern fill count and element decoding of the newest byte
  gwm_loader u_loader (
    .clk        (clk),
    .rst_n      (rst_n),
    .do_clear   (do_clear),
    .do_append  (do_append),
    .append_chr (in_ch.char_value),
    .load       (load),
    .count      (count),
    .overflowed (overflowed)
  );

  // broadcast to the whole row; the name byte is folded once here
  always_comb begin
    cmd.clear  = do_clear;
    cmd.append = do_append;
    cmd.step   = do_step;
    cmd.finish = do_finish;
    cmd.ci     = ci_r;
    cmd.fc     = fold(in_ch.char_value, ci_r);
    cmd.role   = load.role;
    cmd.chr    = load.chr;
    cmd.inv    = load.inv;
  end

  // the row: one cell per pattern position plus the accept position
  assign link[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    always_comb begin
      ctl[i].home  = (i == 0);
      ctl[i].valid = (POS_W'(i) < count);
      ctl[i].wr    = load.wr && (load.pos == POS_W'(i));
    end

    gwm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[i]),
      .cmd      (cmd),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .act      (act_vec[i])
    );
  end

  // result: the position just past the pattern is the accept state
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_matched_nxt  = out_matched_r;
    out_overflow_nxt = out_overflow_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (do_finish) begin
      out_valid_nxt    = 1'b1;
      out_matched_nxt  = !overflowed && act_vec[count];
      out_overflow_nxt = overflowed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ci_r        <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) ci_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r  <= out_matched_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.matched  = out_matched_r;
  assign out_ch.overflow = out_overflow_r;

`ifndef ASSERT_OFF
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    do_finish |=> out_valid_r)
    else $error("end of name did not load a result");

  a_overflow_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_overflow_r) |-> !out_matched_r)
    else $error("match reported on an overflowed pattern");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflowed |-> (count == POS_W'(PATTERN_MAX)))
    else $error("overflow flagged with room left in the pattern");

  a_clear_restart: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> (count == '0) && (act_vec == NCELL'(1)))
    else $error("clear did not empty the pattern and restart the row");
`endif

endmodule
